// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define B64E_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// trigger at one edge implies consequence at the next
`define B64E_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

// File: rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types and constants of the base64 stream encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'd61;
    localparam int         FIFO_DEPTH = 2;
    localparam int         FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int         ALPHA_REGS = 8;
    localparam int         CFG_AW     = $clog2(ALPHA_REGS) + 3;

    typedef logic [ALPHA_REGS-1:0][63:0] t_alpha;

    typedef struct packed {
        logic       pad;
        logic [5:0] sextet;
    } t_sym;

    // cnt is the index of the final symbol (number of symbols minus one)
    typedef struct packed {
        t_sym [3:0] sym;
        logic [1:0] cnt;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// File: rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// streaming base64 encoder with a software-loaded alphabet
// ----------------------------------------------------------------------------
// s_axis takes one message byte per word in tdata, tlast on the final byte.
// m_axis gives one encoded character per word in tdata, tlast on the final
// character of the message, including the '=' pads.
// the alphabet lives in eight 64-bit apb registers at byte addresses 8*k,
// entry 8k in the low byte of word k; all entries are zero after reset.
// a byte is split into sextets and pads by the front and queued as one
// command of one to four symbols; the back looks each symbol up in the
// alphabet and puts one character per cycle into the free output register.
// once a byte is accepted, its first character passes through the queue,
// the command register and the output register before it is valid on m_axis.
// the back emits one character per cycle while m_axis is ready, so inside
// a group input is paced by four characters per three bytes, one byte per
// cycle while the two-entry queue has room; a final byte gives up to four.
// reset clears phase, leftover bits, queue and output register.
// when m_axis stalls, the output register holds, the queue fills and then
// s_axis_tready drops until characters drain.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // data_byte
    input  logic                        s_axis_tlast,   // last_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // out_char
    output logic                        m_axis_tlast,   // last_char
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [b64e_pkg::CFG_AW-1:0] paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);
    import b64e_pkg::*;

    t_alpha     alpha;
    t_cmd       push_cmd, pop_cmd;
    t_fifo_stat stat;
    logic       push, pop;

    b64e_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_alpha (alpha)
    );

    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data_byte (s_axis_tdata),
        .i_last_byte (s_axis_tlast),
        .i_stat      (stat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    b64e_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_cmd),
        .i_pop   (pop),
        .o_rdata (pop_cmd),
        .o_stat  (stat)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_alpha     (alpha),
        .i_cmd       (pop_cmd),
        .i_stat      (stat),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_out_char  (m_axis_tdata),
        .o_last_char (m_axis_tlast)
    );

endmodule

// File: rtl/b64e_cfg.sv
// ----------------------------------------------------------------------------
// b64e_cfg
// apb register bank holding the eight alphabet words
// ----------------------------------------------------------------------------
module b64e_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [b64e_pkg::CFG_AW-1:0] paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready,
    output b64e_pkg::t_alpha          o_alpha
);
    import b64e_pkg::*;

    t_alpha                          r_alpha;
    logic                            wr_en;
    logic [$clog2(ALPHA_REGS)-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:3];
    assign wr_en   = psel & penable & pwrite & pready;
    assign prdata  = r_alpha[reg_idx];
    assign o_alpha = r_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= '0;
        end else if (wr_en) begin
            r_alpha[reg_idx] <= pwdata;
        end
    end

endmodule

// File: rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// accepts input bytes, splits them into sextets and pads, queues a command
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64e_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    input  b64e_pkg::t_fifo_stat i_stat,
    output logic                 o_push,
    output b64e_pkg::t_cmd       o_cmd
);
    import b64e_pkg::*;

    localparam logic [1:0] PH0 = 2'd0;
    localparam logic [1:0] PH1 = 2'd1;
    localparam logic [1:0] PH2 = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [5:0] r_left, n_left;
    logic       accept;
    t_cmd       cmd;

    assign o_ready = !i_stat.full;
    assign accept  = i_valid & o_ready;

    always_comb begin
        cmd      = '0;
        cmd.last = i_last_byte;
        unique case (r_phase)
            PH1: begin
                cmd.sym[0].sextet = r_left | {2'b00, i_data_byte[7:4]};
                n_left            = {i_data_byte[3:0], 2'b00};
                n_phase           = PH2;
                if (i_last_byte) begin
                    cmd.sym[1].sextet = n_left;
                    cmd.sym[2].pad    = 1'b1;
                    cmd.cnt           = 2'd2;
                end
            end
            PH2: begin
                cmd.sym[0].sextet = r_left | {4'b0000, i_data_byte[7:6]};
                cmd.sym[1].sextet = i_data_byte[5:0];
                cmd.cnt           = 2'd1;
                n_left            = '0;
                n_phase           = PH0;
            end
            default: begin
                cmd.sym[0].sextet = i_data_byte[7:2];
                n_left            = {i_data_byte[1:0], 4'b0000};
                n_phase           = PH1;
                if (i_last_byte) begin
                    cmd.sym[1].sextet = n_left;
                    cmd.sym[2].pad    = 1'b1;
                    cmd.sym[3].pad    = 1'b1;
                    cmd.cnt           = 2'd3;
                end
            end
        endcase
        if (i_last_byte) begin
            n_phase = PH0;
            n_left  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH0;
            r_left  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    assign o_push = accept;
    assign o_cmd  = cmd;

    `B64E_ASSERT_NEXT(a_last_restarts, accept && i_last_byte, r_phase == PH0 && r_left == 6'd0, "phase not cleared after last byte")

endmodule

// File: rtl/b64e_fifo.sv
// ----------------------------------------------------------------------------
// b64e_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64e_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64e_pkg::t_cmd       i_wdata,
    input  logic                 i_pop,
    output b64e_pkg::t_cmd       o_rdata,
    output b64e_pkg::t_fifo_stat o_stat
);
    import b64e_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_AW:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH)) ? 1'b1 : 1'b0;
    assign o_stat.empty = (r_cnt == '0);
    assign o_rdata      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `B64E_ASSERT(a_no_overflow, !(i_push && o_stat.full), "push into full queue")
    `B64E_ASSERT(a_no_underflow, !(i_pop && o_stat.empty), "pop from empty queue")

endmodule

// File: rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// walks queued commands one symbol per cycle through the alphabet unless held
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64e_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  b64e_pkg::t_alpha     i_alpha,
    input  b64e_pkg::t_cmd       i_cmd,
    input  b64e_pkg::t_fifo_stat i_stat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_char,
    output logic                 o_last_char
);
    import b64e_pkg::*;

    t_cmd       r_cmd;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic       load_out, emit, done;
    t_sym       sym;
    logic [7:0] ch;

    assign load_out = !r_out_valid || i_ready;
    assign emit     = r_busy && load_out;
    assign done     = emit && (r_idx == r_cmd.cnt);
    assign o_pop    = !i_stat.empty && (!r_busy || done);

    assign sym = r_cmd.sym[r_idx];
    assign ch  = sym.pad ? PAD_CHAR
                         : i_alpha[sym.sextet[5:3]][{sym.sextet[2:0], 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out_char <= ch;
            r_out_last <= r_cmd.last && (r_idx == r_cmd.cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= emit;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

    `B64E_ASSERT(a_idx_in_range, !r_busy || (r_idx <= r_cmd.cnt), "symbol index past command")

endmodule
